// ===== hw/rtl/dlko_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dlko_pkg: shared types and constants
// Status codes, percentage scaling constants and the control bundle of the
// rank counter.
// ----------------------------------------------------------------------------
package dlko_pkg;

    localparam int LEVEL_W   = 16;
    localparam int INDEX_W   = 6;
    localparam int KEPT_W    = 7;
    localparam int STATUS_W  = 2;
    localparam int PCT_CFG_W = 8;

    localparam int PCT_W = 7;
    localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

    // floor(x / 100) equals (x * 5243) >> 19 for every x below 43699.
    localparam int RECIP_W = 13;
    localparam logic [RECIP_W-1:0] RECIP_MUL = 13'd5243;
    localparam int RECIP_SHIFT = 19;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_TOO_FEW  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;

    typedef struct packed {
        logic capture_ref;
        logic compare;
    } rank_ctrl_t;

endpackage
`default_nettype wire

// ===== hw/rtl/dlko_store.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dlko_store: level memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module dlko_store #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire logic                        aclk,
    input  wire logic                        wr_en,
    input  wire logic [AW-1:0]               wr_addr,
    input  wire logic [dlko_pkg::LEVEL_W-1:0] wr_data,
    input  wire logic [AW-1:0]               rd_addr,
    output logic      [dlko_pkg::LEVEL_W-1:0] rd_data
);

    logic [dlko_pkg::LEVEL_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

// ===== hw/rtl/dlko_rank.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dlko_rank: shared rank counter
// Holds the level under test and counts the stored levels that order below
// it, comparing by level and then by index, one level per cycle.
// ----------------------------------------------------------------------------
module dlko_rank #(
    parameter int IW = 6,
    parameter int CW = 7
) (
    input  wire logic                         aclk,
    input  wire dlko_pkg::rank_ctrl_t         ctrl,
    input  wire logic [dlko_pkg::LEVEL_W-1:0] rd_data,
    input  wire logic [IW-1:0]                ref_idx,
    input  wire logic [IW-1:0]                cmp_idx,
    output logic      [CW-1:0]                rank
);

    logic [dlko_pkg::LEVEL_W-1:0] ref_level_reg;
    logic [CW-1:0]                rank_reg;
    logic                         below;

    assign below = {rd_data, cmp_idx} < {ref_level_reg, ref_idx};
    assign rank  = rank_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.capture_ref) begin
            ref_level_reg <= rd_data;
            rank_reg      <= '0;
        end else if (ctrl.compare && below) begin
            rank_reg <= rank_reg + CW'(1);
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/drop_lowest_keep_order_unit.sv =====
`default_nettype none
// A level is taken whenever the unit is idle, the last level of a list included.
// After the last level, the unit forms the k product and then the quotient; each
// interior position is then ranked by a scan through the single memory read port,
// and the first and last positions and each kept interior one go out as results.
// Reset (synchronous, active low) empties the list and clears the percentage in pct_reg.
// ----------------------------------------------------------------------------
// drop_lowest_keep_order_unit: drops the lowest interior levels of a list
// Stores a list of levels, ranks each interior position against the others
// with one shared comparator, and sends out the kept indices in order.
// ----------------------------------------------------------------------------
module drop_lowest_keep_order_unit #(
    parameter int MAX_POSITIONS = 64
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wen,
    input  wire logic [dlko_pkg::PCT_CFG_W-1:0]  cfg_wdata,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [dlko_pkg::LEVEL_W-1:0]    s_level,
    input  wire logic                            s_last_item,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic      [dlko_pkg::INDEX_W-1:0]    m_position_index,
    output logic                                 m_last_result,
    output logic      [dlko_pkg::KEPT_W-1:0]     m_kept_count,
    output logic      [dlko_pkg::STATUS_W-1:0]   m_status
);

    localparam int IW = $clog2(MAX_POSITIONS);
    localparam int CW = $clog2(MAX_POSITIONS + 1);
    localparam int PW = dlko_pkg::PCT_W + CW;
    localparam int MW = PW + dlko_pkg::RECIP_W;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_PROD   = 9'b000000010,
        S_DIV    = 9'b000000100,
        S_NEXT   = 9'b000001000,
        S_LATCH  = 9'b000010000,
        S_SCAN   = 9'b000100000,
        S_DRAIN  = 9'b001000000,
        S_DECIDE = 9'b010000000,
        S_EMIT   = 9'b100000000
    } state_t;

    state_t                          state_reg, state_next;
    logic [dlko_pkg::PCT_CFG_W-1:0]  pct_reg;
    logic [CW-1:0]                   count_reg, count_next;
    logic                            ovf_reg, ovf_next;
    logic [IW-1:0]                   i_reg, i_next;
    logic [IW-1:0]                   j_reg, j_next;
    logic [PW-1:0]                   prod_reg, prod_next;
    logic [CW-1:0]                   k_reg, k_next;
    logic                            cmp_valid_reg, cmp_valid_next;
    logic [IW-1:0]                   cmp_idx_reg, cmp_idx_next;

    logic [dlko_pkg::INDEX_W-1:0]    idx_reg, idx_next;
    logic                            last_reg, last_next;
    logic [dlko_pkg::KEPT_W-1:0]     kept_reg, kept_next;
    logic [dlko_pkg::STATUS_W-1:0]   status_reg, status_next;

    logic                            full;
    logic                            wr_en;
    logic [IW-1:0]                   rd_addr;
    logic [dlko_pkg::LEVEL_W-1:0]    rd_data;
    logic [CW-1:0]                   rank;
    logic [dlko_pkg::PCT_W-1:0]      pct_cap;
    logic [MW-1:0]                   quot_full;
    logic                            i_is_last;
    dlko_pkg::rank_ctrl_t            rank_ctrl;

    assign full      = (count_reg == CW'(MAX_POSITIONS));
    assign pct_cap   = (pct_reg > dlko_pkg::PCT_CFG_W'(dlko_pkg::PCT_FULL))
                       ? dlko_pkg::PCT_FULL : pct_reg[dlko_pkg::PCT_W-1:0];
    assign quot_full = (MW'(prod_reg) * MW'(dlko_pkg::RECIP_MUL)) >> dlko_pkg::RECIP_SHIFT;
    assign i_is_last = (CW'(i_reg) == count_reg - CW'(1));

    assign s_ready          = (state_reg == S_IDLE);
    assign m_valid          = (state_reg == S_EMIT);
    assign m_position_index = idx_reg;
    assign m_last_result    = last_reg;
    assign m_kept_count     = kept_reg;
    assign m_status         = status_reg;

    assign rank_ctrl.capture_ref = (state_reg == S_LATCH);
    assign rank_ctrl.compare     = cmp_valid_reg;

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        prod_next      = prod_reg;
        k_next         = k_reg;
        cmp_valid_next = 1'b0;
        cmp_idx_next   = j_reg;
        idx_next       = idx_reg;
        last_next      = last_reg;
        kept_next      = kept_reg;
        status_next    = status_reg;
        wr_en          = 1'b0;
        rd_addr        = i_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    wr_en      = !full;
                    count_next = full ? count_reg : count_reg + CW'(1);
                    ovf_next   = ovf_reg | full;
                    if (s_last_item) begin
                        if (count_next <= CW'(1)) begin
                            idx_next    = '0;
                            last_next   = 1'b1;
                            kept_next   = '0;
                            status_next = dlko_pkg::ST_TOO_FEW;
                            state_next  = S_EMIT;
                        end else begin
                            state_next = S_PROD;
                        end
                    end
                end
            end
            S_PROD: begin
                prod_next  = PW'(pct_cap) * PW'(count_reg - CW'(2));
                i_next     = '0;
                state_next = S_DIV;
            end
            S_DIV: begin
                k_next     = CW'(quot_full);
                state_next = S_NEXT;
            end
            S_NEXT: begin
                if (i_reg == '0 || i_is_last) begin
                    idx_next    = dlko_pkg::INDEX_W'(i_reg);
                    last_next   = i_is_last;
                    kept_next   = dlko_pkg::KEPT_W'(count_reg - k_reg);
                    status_next = ovf_reg ? dlko_pkg::ST_OVERFLOW : dlko_pkg::ST_OK;
                    state_next  = S_EMIT;
                end else begin
                    state_next = S_LATCH;
                end
            end
            S_LATCH: begin
                j_next     = IW'(1);
                state_next = S_SCAN;
            end
            S_SCAN: begin
                rd_addr        = j_reg;
                cmp_valid_next = 1'b1;
                cmp_idx_next   = j_reg;
                if (CW'(j_reg) == count_reg - CW'(2)) begin
                    state_next = S_DRAIN;
                end else begin
                    j_next = j_reg + IW'(1);
                end
            end
            S_DRAIN: begin
                state_next = S_DECIDE;
            end
            S_DECIDE: begin
                if (rank >= k_reg) begin
                    idx_next    = dlko_pkg::INDEX_W'(i_reg);
                    last_next   = 1'b0;
                    kept_next   = dlko_pkg::KEPT_W'(count_reg - k_reg);
                    status_next = ovf_reg ? dlko_pkg::ST_OVERFLOW : dlko_pkg::ST_OK;
                    state_next  = S_EMIT;
                end else begin
                    i_next     = i_reg + IW'(1);
                    state_next = S_NEXT;
                end
            end
            S_EMIT: begin
                if (m_ready) begin
                    if (last_reg) begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                        state_next = S_IDLE;
                    end else begin
                        i_next     = i_reg + IW'(1);
                        state_next = S_NEXT;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            pct_reg       <= '0;
            cmp_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            cmp_valid_reg <= cmp_valid_next;
            if (cfg_wen) begin
                pct_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        i_reg       <= i_next;
        j_reg       <= j_next;
        prod_reg    <= prod_next;
        k_reg       <= k_next;
        cmp_idx_reg <= cmp_idx_next;
        idx_reg     <= idx_next;
        last_reg    <= last_next;
        kept_reg    <= kept_next;
        status_reg  <= status_next;
    end

    dlko_store #(
        .DEPTH (MAX_POSITIONS),
        .AW    (IW)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[IW-1:0]),
        .wr_data (s_level),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    dlko_rank #(
        .IW (IW),
        .CW (CW)
    ) u_rank (
        .aclk    (aclk),
        .ctrl    (rank_ctrl),
        .rd_data (rd_data),
        .ref_idx (i_reg),
        .cmp_idx (cmp_idx_reg),
        .rank    (rank)
    );

endmodule
`default_nettype wire

// ===== hw/rtl/dlko_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dlko_checker: port-level assertions
// Checks the transfer behaviour and result coding seen at the top-level ports.
// ----------------------------------------------------------------------------
module dlko_checker (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            s_ready,
    input wire logic                            m_valid,
    input wire logic                            m_ready,
    input wire logic [dlko_pkg::INDEX_W-1:0]    m_position_index,
    input wire logic                            m_last_result,
    input wire logic [dlko_pkg::KEPT_W-1:0]     m_kept_count,
    input wire logic [dlko_pkg::STATUS_W-1:0]   m_status
);

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("Input taken while a result is pending.");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_position_index)
            && $stable(m_last_result) && $stable(m_kept_count) && $stable(m_status)))
        else $error("Stalled result changed before its transfer.");

    a_too_few_form: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == dlko_pkg::ST_TOO_FEW)
            |-> (m_last_result && m_kept_count == '0 && m_position_index == '0))
        else $error("Malformed too-few result.");

    a_kept_min: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status == dlko_pkg::ST_OK || m_status == dlko_pkg::ST_OVERFLOW))
            |-> (m_kept_count >= dlko_pkg::KEPT_W'(2)))
        else $error("A normal run keeps fewer than two positions.");

    a_run_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last_result) |=> !s_ready)
        else $error("Input accepted before the run of results ended.");

endmodule

bind drop_lowest_keep_order_unit dlko_checker u_dlko_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_ready          (s_ready),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_position_index (m_position_index),
    .m_last_result    (m_last_result),
    .m_kept_count     (m_kept_count),
    .m_status         (m_status)
);
`default_nettype wire
